>>> sv/medenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// medenc_pkg
// Shared constants for the MIDI note-event delta encoder: tick width,
// variable-length group layout and status byte codes.
// ----------------------------------------------------------------------------
package medenc_pkg;

  localparam int TICK_BITS  = 28;
  localparam int FIELD_TICK = 28;
  localparam int GROUP_BITS = 7;
  localparam int NUM_GROUPS = (TICK_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int PAD_BITS   = NUM_GROUPS * GROUP_BITS;
  localparam int TOP_BITS   = TICK_BITS - (NUM_GROUPS - 1) * GROUP_BITS;
  localparam int CNT_W      = $clog2(NUM_GROUPS + 1);

  localparam logic [GROUP_BITS-1:0] GROUP_MASK = {GROUP_BITS{1'b1}};
  localparam logic [GROUP_BITS-1:0] TOP_MASK   = GROUP_BITS'((1 << TOP_BITS) - 1);

  localparam logic [3:0] STATUS_ON     = 4'h9;
  localparam logic [3:0] STATUS_OFF    = 4'h8;
  localparam logic [3:0] CHANNEL_RESET = 4'd9;

endpackage
`default_nettype wire

>>> sv/midi_event_delta_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_event_delta_encoder_core
// Forms the tick delta to the previous event seven bits per cycle and sends
// it as a variable-length quantity, then status, note and velocity bytes.
// ----------------------------------------------------------------------------
// Items are taken one at a time: the input stalls through the digit-serial
//   subtract, the group shift register and the byte phase, until the
//   velocity byte of the item is issued.
// Output stalls hold the byte phase for as long as they last.
// Reset: previous tick clears to zero, channel returns to 9, no item pending.

module midi_event_delta_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        midi_channel_we_i,
  input  wire logic [3:0]  midi_channel_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [27:0] event_tick_i,
  input  wire logic        note_on_i,
  input  wire logic [6:0]  note_number_i,
  input  wire logic [6:0]  velocity_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_byte_o
);

  localparam int GB = medenc_pkg::GROUP_BITS;
  localparam int PW = medenc_pkg::PAD_BITS;
  localparam int CW = medenc_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_DELTA,
    ST_STATUS,
    ST_NOTE,
    ST_VEL
  } state_e;

  state_e         state_q, state_d;
  logic [3:0]     chan_q, chan_d;
  logic [PW-1:0]  tick_q, tick_d;
  logic [PW-1:0]  prev_q, prev_d;
  logic [PW-1:0]  delta_q, delta_d;
  logic           borrow_q, borrow_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  grp_q, grp_d;
  logic           on_q, on_d;
  logic [6:0]     note_q, note_d;
  logic [6:0]     vel_q, vel_d;
  logic           oval_q, oval_d;
  logic [7:0]     obyte_q, obyte_d;
  logic           olast_q, olast_d;

  logic           in_acc;
  logic           out_free;
  logic [GB:0]    diff;
  logic [GB-1:0]  dig;
  logic           top_dig;
  logic [GB-1:0]  head;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !oval_q || !out_stall_i;
  assign top_dig  = (cnt_q == CW'(medenc_pkg::NUM_GROUPS - 1));
  assign diff     = {1'b0, tick_q[GB-1:0]} - {1'b0, prev_q[GB-1:0]} - {{GB{1'b0}}, borrow_q};
  assign dig      = diff[GB-1:0] & (top_dig ? medenc_pkg::TOP_MASK : medenc_pkg::GROUP_MASK);
  assign head     = delta_q[PW-1 -: GB];

  always_comb begin
    state_d  = state_q;
    chan_d   = midi_channel_we_i ? midi_channel_i : chan_q;
    tick_d   = tick_q;
    prev_d   = prev_q;
    delta_d  = delta_q;
    borrow_d = borrow_q;
    cnt_d    = cnt_q;
    grp_d    = grp_q;
    on_d     = on_q;
    note_d   = note_q;
    vel_d    = vel_q;
    oval_d   = oval_q && out_stall_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          tick_d   = PW'(event_tick_i[medenc_pkg::TICK_BITS-1:0]);
          on_d     = note_on_i;
          note_d   = note_number_i;
          vel_d    = note_on_i ? velocity_i : 7'd0;
          borrow_d = 1'b0;
          cnt_d    = '0;
          grp_d    = CW'(1);
          state_d  = ST_SUB;
        end
      end
      ST_SUB: begin
        tick_d   = tick_q >> GB;
        prev_d   = (prev_q >> GB) | (PW'(tick_q[GB-1:0]) << (PW - GB));
        delta_d  = (delta_q >> GB) | (PW'(dig) << (PW - GB));
        borrow_d = diff[GB];
        if (dig != '0) begin
          grp_d = cnt_q + CW'(1);
        end
        if (top_dig) begin
          cnt_d   = CW'(medenc_pkg::NUM_GROUPS);
          state_d = ST_DELTA;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DELTA: begin
        if (cnt_q != grp_q) begin
          delta_d = delta_q << GB;
          cnt_d   = cnt_q - CW'(1);
        end else if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = {(cnt_q != CW'(1)), head};
          olast_d = 1'b0;
          delta_d = delta_q << GB;
          cnt_d   = cnt_q - CW'(1);
          grp_d   = grp_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = {(on_q ? medenc_pkg::STATUS_ON : medenc_pkg::STATUS_OFF), chan_q};
          olast_d = 1'b0;
          state_d = ST_NOTE;
        end
      end
      ST_NOTE: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = {1'b0, note_q};
          olast_d = 1'b0;
          state_d = ST_VEL;
        end
      end
      ST_VEL: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = {1'b0, vel_q};
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chan_q   <= medenc_pkg::CHANNEL_RESET;
      prev_q   <= '0;
      oval_q   <= 1'b0;
      borrow_q <= 1'b0;
      cnt_q    <= '0;
      grp_q    <= '0;
    end else begin
      state_q  <= state_d;
      chan_q   <= chan_d;
      prev_q   <= prev_d;
      oval_q   <= oval_d;
      borrow_q <= borrow_d;
      cnt_q    <= cnt_d;
      grp_q    <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q  <= tick_d;
    delta_q <= delta_d;
    on_q    <= on_d;
    note_q  <= note_d;
    vel_q   <= vel_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign last_byte_o = olast_q;

endmodule
`default_nettype wire

>>> sv/medenc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// medenc_checker
// Port-level checks on the MIDI note-event delta encoder, bound to the core.
// ----------------------------------------------------------------------------
module medenc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_byte_o
);

  // hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_byte_o))
    else $error("stalled output item changed");

  // busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  // velocity byte never carries a continuation bit
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> !out_byte_o[7])
    else $error("final byte has bit 7 set");

  // no final byte follows a delta byte without continuation while idle
  a_status_after_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_o && !out_byte_o[7] && !in_stall_o
      |=> !(out_valid_o && last_byte_o && !in_stall_o))
    else $error("final byte follows a data byte while idle");

endmodule

bind midi_event_delta_encoder_core medenc_checker u_medenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .last_byte_o (last_byte_o)
);
`default_nettype wire
